/* sv/datr_pkg.sv */
// Package with the shared types and constants of the double-array trie engine.
package datr_pkg;

    localparam int OP_W     = 2;
    localparam int LETTER_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_STEP,
        S_CUR,
        S_TGT,
        S_KRD,
        S_KCK,
        S_SRD,
        S_SCK,
        S_BASE,
        S_MRD,
        S_MWR,
        S_GRD,
        S_GCK,
        S_MCLR,
        S_NEW,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

/* sv/datr_mem.sv */
// Node store memory with one write port and one registered read port.
module datr_mem #(
    parameter int AW = 16,
    parameter int WW = 33,
    parameter int DEPTH = 65536
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [WW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [WW-1:0] o_rdata
);

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/double_array_trie_engine.sv */
// Top level of the double-array trie engine: sequencer around the node store.
//
// A request carries one letter, an op (insert, search, prefix) and a
// word_end flag. It is taken at a rising edge where start is high and busy
// is low. Letters of a word are sent one request at a time. After the
// request marked word_end the block pulses o_valid for one cycle with
// o_found and o_status; no other request gives a result.
// Each node is one word of a single-port-read, single-port-write memory
// holding a valid bit, the parent check and the child offset. A lookup
// step costs two memory reads. An insert that hits a foreign slot
// relocates the children of the current node: a gather of its children,
// a scan of candidate offsets until one has every needed slot free, and
// per moved child a copy of it and a repointing of its children.
// After reset a clearing pass writes every entry of the node store, while
// busy stays high. The receiver cannot stall: a result is shown once and
// must be taken in that cycle.
module double_array_trie_engine #(
    parameter int NODES = 65536,
    parameter int CODES = 27
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [datr_pkg::OP_W-1:0]      i_op,
    input  logic [datr_pkg::LETTER_W-1:0]  i_letter,
    input  logic                           i_word_end,
    output logic                           o_valid,
    output logic                           o_found,
    output logic                           o_status
);

    import datr_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int WW = 2 * AW + 1;
    localparam int CW = $clog2(CODES + 1);
    localparam int VB = 2 * AW;

    localparam logic [AW:0]   LIMIT   = (AW + 1)'(NODES);
    localparam logic [CW-1:0] END_CODE = CW'(CODES);
    localparam logic [WW-1:0] ROOT_WORD = {1'b1, {AW{1'b0}}, AW'(1)};

    t_state r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [OP_W-1:0]    r_op, n_op;
    logic [CW-1:0]      r_code, n_code;
    logic               r_last, n_last;
    logic               r_phase_end, n_phase_end;
    logic [AW-1:0]      r_cursor, n_cursor;
    logic               r_miss, n_miss;
    logic               r_full, n_full;
    logic [AW-1:0]      r_cur_check, n_cur_check;
    logic [AW-1:0]      r_t, n_t;
    logic [AW-1:0]      r_old, n_old;
    logic [CODES-1:0]   r_kids, n_kids;
    logic [CODES-1:0]   r_mask, n_mask;
    logic [CODES-1:0]   r_pend, n_pend;
    logic [CW-1:0]      r_c, n_c;
    logic [AW:0]        r_nb, n_nb;
    logic [AW-1:0]      r_o, n_o;
    logic [AW-1:0]      r_n, n_n;
    logic [AW-1:0]      r_obase, n_obase;
    logic [CW-1:0]      r_g, n_g;
    logic [AW-1:0]      r_gi, n_gi;
    logic               r_valid, n_valid;
    logic               r_found, n_found;
    logic               r_status, n_status;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [WW-1:0] mem_wdata, mem_rdata;

    logic          rd_valid;
    logic [AW-1:0] rd_check, rd_base;
    logic [CW-1:0] in_code, low_c;
    logic [AW:0]   sum_a;
    logic [CODES-1:0] code_bit, kids_upd, pend_clr;
    logic          is_insert;

    datr_mem #(
        .AW    (AW),
        .WW    (WW),
        .DEPTH (NODES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_valid = mem_rdata[VB];
    assign rd_check = mem_rdata[VB-1:AW];
    assign rd_base  = mem_rdata[AW-1:0];
    assign is_insert = (r_op == OP_INSERT);

    always_comb begin
        logic [7:0] lx;
        lx = {3'b000, i_letter};
        if (lx > 8'(CODES - 2)) begin
            in_code = CW'(CODES - 1);
        end else begin
            in_code = CW'(lx + 8'd1);
        end
    end

    always_comb begin
        low_c = '0;
        for (int i = CODES - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                low_c = CW'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cursor <= '0;
            r_miss   <= 1'b0;
            r_full   <= 1'b0;
            r_phase_end <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cursor <= n_cursor;
            r_miss   <= n_miss;
            r_full   <= n_full;
            r_phase_end <= n_phase_end;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_code      <= n_code;
        r_last      <= n_last;
        r_cur_check <= n_cur_check;
        r_t         <= n_t;
        r_old       <= n_old;
        r_kids      <= n_kids;
        r_mask      <= n_mask;
        r_pend      <= n_pend;
        r_c         <= n_c;
        r_nb        <= n_nb;
        r_o         <= n_o;
        r_n         <= n_n;
        r_obase     <= n_obase;
        r_g         <= n_g;
        r_gi        <= n_gi;
        r_found     <= n_found;
        r_status    <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_code      = r_code;
        n_last      = r_last;
        n_phase_end = r_phase_end;
        n_cursor    = r_cursor;
        n_miss      = r_miss;
        n_full      = r_full;
        n_cur_check = r_cur_check;
        n_t         = r_t;
        n_old       = r_old;
        n_kids      = r_kids;
        n_mask      = r_mask;
        n_pend      = r_pend;
        n_c         = r_c;
        n_nb        = r_nb;
        n_o         = r_o;
        n_n         = r_n;
        n_obase     = r_obase;
        n_g         = r_g;
        n_gi        = r_gi;
        n_valid     = 1'b0;
        n_found     = r_found;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        sum_a       = '0;
        code_bit    = '0;
        kids_upd    = r_kids;
        pend_clr    = r_pend;

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr == '0) ? ROOT_WORD : '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op        = i_op;
                    n_code      = in_code;
                    n_last      = i_word_end;
                    n_phase_end = 1'b0;
                    n_state     = S_STEP;
                end
            end
            S_STEP: begin
                if (r_miss || r_full) begin
                    n_state = S_NEXT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_cursor;
                    n_state   = S_CUR;
                end
            end
            S_CUR: begin
                n_cur_check = rd_check;
                n_old       = rd_base;
                sum_a       = {1'b0, rd_base} + (AW + 1)'(r_code);
                if (sum_a >= LIMIT) begin
                    if (is_insert) begin
                        n_full = 1'b1;
                    end else begin
                        n_miss = 1'b1;
                    end
                    n_state = S_NEXT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = sum_a[AW-1:0];
                    n_t       = sum_a[AW-1:0];
                    n_state   = S_TGT;
                end
            end
            S_TGT: begin
                if (!is_insert) begin
                    if (rd_valid && rd_check == r_cursor) begin
                        n_cursor = r_t;
                    end else begin
                        n_miss = 1'b1;
                    end
                    n_state = S_NEXT;
                end else if (!rd_valid) begin
                    n_state = S_NEW;
                end else if (rd_check == r_cursor) begin
                    n_cursor = r_t;
                    n_state  = S_NEXT;
                end else begin
                    n_kids  = '0;
                    n_c     = CW'(1);
                    n_state = S_KRD;
                end
            end
            S_KRD: begin
                sum_a = {1'b0, r_old} + (AW + 1)'(r_c);
                if (sum_a < LIMIT) begin
                    mem_re    = 1'b1;
                    mem_raddr = sum_a[AW-1:0];
                    n_state   = S_KCK;
                end else if (r_c == END_CODE) begin
                    code_bit = CODES'(1) << (r_code - CW'(1));
                    n_mask   = r_kids | code_bit;
                    n_pend   = r_kids | code_bit;
                    n_nb     = {1'b0, r_old} + (AW + 1)'(1);
                    n_state  = S_SRD;
                end else begin
                    n_c = r_c + CW'(1);
                end
            end
            S_KCK: begin
                if (rd_valid && rd_check == r_cursor) begin
                    kids_upd[r_c - CW'(1)] = 1'b1;
                end
                n_kids = kids_upd;
                if (r_c == END_CODE) begin
                    code_bit = CODES'(1) << (r_code - CW'(1));
                    n_mask   = kids_upd | code_bit;
                    n_pend   = kids_upd | code_bit;
                    n_nb     = {1'b0, r_old} + (AW + 1)'(1);
                    n_state  = S_SRD;
                end else begin
                    n_c     = r_c + CW'(1);
                    n_state = S_KRD;
                end
            end
            S_SRD: begin
                sum_a = r_nb + (AW + 1)'(low_c);
                if (r_nb >= LIMIT) begin
                    n_full  = 1'b1;
                    n_state = S_NEXT;
                end else if (sum_a >= LIMIT) begin
                    n_nb   = r_nb + (AW + 1)'(1);
                    n_pend = r_mask;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = sum_a[AW-1:0];
                    n_c       = low_c;
                    n_state   = S_SCK;
                end
            end
            S_SCK: begin
                if (rd_valid) begin
                    n_nb    = r_nb + (AW + 1)'(1);
                    n_pend  = r_mask;
                    n_state = S_SRD;
                end else begin
                    pend_clr[r_c - CW'(1)] = 1'b0;
                    n_pend = pend_clr;
                    if (pend_clr == '0) begin
                        n_state = S_BASE;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_BASE: begin
                mem_we    = 1'b1;
                mem_waddr = r_cursor;
                mem_wdata = {1'b1, r_cur_check, r_nb[AW-1:0]};
                sum_a     = r_nb + (AW + 1)'(r_code);
                n_t       = sum_a[AW-1:0];
                n_c       = CW'(1);
                n_state   = S_MRD;
            end
            S_MRD: begin
                if (r_kids[r_c - CW'(1)]) begin
                    sum_a     = {1'b0, r_old} + (AW + 1)'(r_c);
                    mem_re    = 1'b1;
                    mem_raddr = sum_a[AW-1:0];
                    n_o       = sum_a[AW-1:0];
                    sum_a     = r_nb + (AW + 1)'(r_c);
                    n_n       = sum_a[AW-1:0];
                    n_state   = S_MWR;
                end else if (r_c == END_CODE) begin
                    n_state = S_NEW;
                end else begin
                    n_c = r_c + CW'(1);
                end
            end
            S_MWR: begin
                n_obase   = rd_base;
                mem_we    = 1'b1;
                mem_waddr = r_n;
                mem_wdata = {1'b1, r_cursor, rd_base};
                n_g       = CW'(1);
                n_state   = S_GRD;
            end
            S_GRD: begin
                sum_a = {1'b0, r_obase} + (AW + 1)'(r_g);
                if (sum_a < LIMIT) begin
                    mem_re    = 1'b1;
                    mem_raddr = sum_a[AW-1:0];
                    n_gi      = sum_a[AW-1:0];
                    n_state   = S_GCK;
                end else if (r_g == END_CODE) begin
                    n_state = S_MCLR;
                end else begin
                    n_g = r_g + CW'(1);
                end
            end
            S_GCK: begin
                if (rd_valid && rd_check == r_o) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_gi;
                    mem_wdata = {1'b1, r_n, rd_base};
                end
                if (r_g == END_CODE) begin
                    n_state = S_MCLR;
                end else begin
                    n_g     = r_g + CW'(1);
                    n_state = S_GRD;
                end
            end
            S_MCLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_o;
                mem_wdata = '0;
                if (r_c == END_CODE) begin
                    n_state = S_NEW;
                end else begin
                    n_c     = r_c + CW'(1);
                    n_state = S_MRD;
                end
            end
            S_NEW: begin
                mem_we    = 1'b1;
                mem_waddr = r_t;
                mem_wdata = {1'b1, r_cursor, AW'(1)};
                n_cursor  = r_t;
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                if (r_last && !r_phase_end) begin
                    n_phase_end = 1'b1;
                    n_code      = END_CODE;
                    if (!r_miss && !r_full && (r_op == OP_INSERT || r_op == OP_SEARCH)) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                n_valid  = 1'b1;
                n_found  = !r_miss && !r_full;
                n_status = r_full;
                n_cursor = '0;
                n_miss   = 1'b0;
                n_full   = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_found  = r_found;
    assign o_status = r_status;

endmodule
